// ===== hw/rtl/itar_pkg.sv =====
// Shared constants, types and helpers for the integer-to-ASCII converter.
`default_nettype none

package itar_pkg;

   // Field widths and default value width
   localparam int DEF_VALUE_WIDTH = 32;
   localparam int RADIX_W         = 6;
   localparam int DIGIT_W         = 6;
   localparam int CHAR_W          = 8;

   // Radix clamp limits
   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

   // Character constants
   localparam logic [DIGIT_W-1:0] DIGIT_LIMIT = DIGIT_W'(10);
   localparam logic [CHAR_W-1:0]  CH_ZERO     = 8'h30;        // '0'
   localparam logic [CHAR_W-1:0]  CH_ALPHA    = 8'h41 - 8'd10; // 'A' - 10
   localparam logic [CHAR_W-1:0]  CH_MINUS    = 8'h2D;        // '-'

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_READ,
      ST_SHOW
   } state_type;

   // Control from sequencer to divider
   typedef struct packed {
      logic load;
      logic step;
   } div_ctrl_type;

   // Status from divider to sequencer
   typedef struct packed {
      logic               digit_done;
      logic               quot_zero;
      logic [DIGIT_W-1:0] digit;
   } div_status_type;

   // Digit value to ASCII code
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] d_ext;
      d_ext = CHAR_W'(d);
      if (d >= DIGIT_LIMIT) begin
         return d_ext + CH_ALPHA;
      end
      return d_ext + CH_ZERO;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/itar_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module itar_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/itar_div.sv =====
// Bit-serial restoring divider: peels one digit off the magnitude per pass.
`default_nettype none

module itar_div #(
   parameter int VALUE_WIDTH = itar_pkg::DEF_VALUE_WIDTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire itar_pkg::div_ctrl_type         ctrl,
   input  wire logic signed [VALUE_WIDTH-1:0]  load_value,
   input  wire logic [itar_pkg::RADIX_W-1:0]   load_radix,
   output itar_pkg::div_status_type            status
);

   localparam int BW = $clog2(VALUE_WIDTH);
   localparam logic [BW-1:0] BIT_LAST = BW'(VALUE_WIDTH - 1);

   logic [VALUE_WIDTH-1:0]          mag_ff, mag_in;
   logic [itar_pkg::DIGIT_W-1:0]    rem_ff, rem_in;
   logic [itar_pkg::RADIX_W-1:0]    radix_ff, radix_in;
   logic [BW-1:0]                   bit_ff, bit_in;

   logic [itar_pkg::DIGIT_W:0]      shifted;
   logic [itar_pkg::DIGIT_W:0]      diff;
   logic                            qbit;
   logic [VALUE_WIDTH-1:0]          mag_step;
   logic [itar_pkg::DIGIT_W-1:0]    rem_step;
   logic                            last_bit;
   logic [itar_pkg::RADIX_W-1:0]    radix_clamped;
   logic [VALUE_WIDTH-1:0]          magnitude;

   // Clamp radix and form magnitude at load
   always_comb begin
      if (load_radix < itar_pkg::RADIX_MIN) begin
         radix_clamped = itar_pkg::RADIX_MIN;
      end else if (load_radix > itar_pkg::RADIX_MAX) begin
         radix_clamped = itar_pkg::RADIX_MAX;
      end else begin
         radix_clamped = load_radix;
      end
      if (load_value[VALUE_WIDTH-1]) begin
         magnitude = ~load_value + VALUE_WIDTH'(1);
      end else begin
         magnitude = load_value;
      end
   end

   // One restoring step: shift in next dividend bit, subtract if it fits
   always_comb begin
      shifted  = {rem_ff, mag_ff[VALUE_WIDTH-1]};
      diff     = shifted - {1'b0, radix_ff};
      qbit     = (shifted >= {1'b0, radix_ff});
      rem_step = qbit ? diff[itar_pkg::DIGIT_W-1:0] : shifted[itar_pkg::DIGIT_W-1:0];
      mag_step = {mag_ff[VALUE_WIDTH-2:0], qbit};
      last_bit = (bit_ff == BIT_LAST);
   end

   // Next-state for the divider registers
   always_comb begin
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      radix_in = radix_ff;
      bit_in   = bit_ff;
      if (ctrl.load) begin
         mag_in   = magnitude;
         rem_in   = '0;
         radix_in = radix_clamped;
         bit_in   = '0;
      end else if (ctrl.step) begin
         mag_in = mag_step;
         if (last_bit) begin
            rem_in = '0;
            bit_in = '0;
         end else begin
            rem_in = rem_step;
            bit_in = bit_ff + BW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= '0;
      end else begin
         bit_ff <= bit_in;
      end
      mag_ff   <= mag_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
   end

   // Digit is final on the last bit of a pass
   assign status.digit_done = ctrl.step & last_bit;
   assign status.quot_zero  = (mag_step == '0);
   assign status.digit      = rem_step;

endmodule

`default_nettype wire

// ===== hw/rtl/int_to_ascii_radix.sv =====
// Top level: signed integer to ASCII text in radix 2..36, one character per response.
//
//   channel | direction | ports                               | carries
//   req     | in        | req_valid, req_stall, req_value,    | one integer and its radix
//           |           | req_radix                           |
//   rsp     | out       | rsp_valid, rsp_stall,               | one character, last flag
//           |           | rsp_char_code, rsp_last_char        |
//
// Each digit costs one full pass of the bit-serial divider, after a load step;
// then each character takes a digit store read plus show, and a '-' sign for a
// negative number is shown first; rsp_stall can hold the sign or any character.
// A new item is taken only in idle, after the last character has been taken.
// Reset returns the sequencer to idle; the digit store needs no clearing.
// rsp_stall holds the current character and its flag steady.
`default_nettype none

module int_to_ascii_radix #(
   parameter int VALUE_WIDTH = itar_pkg::DEF_VALUE_WIDTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic signed [VALUE_WIDTH-1:0]   req_value,
   input  wire logic [itar_pkg::RADIX_W-1:0]    req_radix,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [itar_pkg::CHAR_W-1:0]          rsp_char_code,
   output logic                                 rsp_last_char
);

   localparam int AW = $clog2(VALUE_WIDTH);
   localparam int CW = $clog2(VALUE_WIDTH + 1);

   itar_pkg::state_type         state_ff, state_in;
   logic [CW-1:0]               count_ff, count_in;
   logic                        neg_ff, neg_in;
   logic [CW-1:0]               count_m1;

   itar_pkg::div_ctrl_type      div_ctrl;
   itar_pkg::div_status_type    div_status;

   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   logic [itar_pkg::DIGIT_W-1:0] rd_data;

   itar_div #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (div_ctrl),
      .load_value (req_value),
      .load_radix (req_radix),
      .status     (div_status)
   );

   // Digit store, written least significant first, read back in reverse
   itar_ram #(
      .WIDTH(itar_pkg::DIGIT_W),
      .DEPTH(VALUE_WIDTH)
   ) u_digits (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (div_status.digit),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign count_m1 = count_ff - CW'(1);

   // Sequencer: next state and outputs
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      neg_in        = neg_ff;
      div_ctrl.load = 1'b0;
      div_ctrl.step = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      rd_en         = 1'b0;
      rd_addr       = count_m1[AW-1:0];
      req_stall     = 1'b1;
      rsp_valid     = 1'b0;
      rsp_char_code = itar_pkg::CH_MINUS;
      rsp_last_char = 1'b0;
      case (state_ff)
         itar_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               div_ctrl.load = 1'b1;
               neg_in        = req_value[VALUE_WIDTH-1];
               count_in      = '0;
               state_in      = itar_pkg::ST_DIVIDE;
            end
         end
         itar_pkg::ST_DIVIDE: begin
            div_ctrl.step = 1'b1;
            if (div_status.digit_done) begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               if (div_status.quot_zero) begin
                  state_in = neg_ff ? itar_pkg::ST_SIGN : itar_pkg::ST_READ;
               end
            end
         end
         itar_pkg::ST_SIGN: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = itar_pkg::ST_READ;
            end
         end
         itar_pkg::ST_READ: begin
            rd_en    = 1'b1;
            state_in = itar_pkg::ST_SHOW;
         end
         itar_pkg::ST_SHOW: begin
            rsp_valid     = 1'b1;
            rsp_char_code = itar_pkg::digit_char(rd_data);
            rsp_last_char = (count_ff == CW'(1));
            if (!rsp_stall) begin
               count_in = count_m1;
               state_in = (count_ff == CW'(1)) ? itar_pkg::ST_IDLE : itar_pkg::ST_READ;
            end
         end
         default: begin
            state_in = itar_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itar_pkg::ST_IDLE;
         count_ff <= '0;
         neg_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         neg_ff   <= neg_in;
      end
   end

endmodule

`default_nettype wire
